@@ sv/combined_lcg_shuffle_rng_defines.svh @@
// Assertion macros shared by the generator's RTL modules.
// Needs signals named clk and rst in the scope of each use.
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CLSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CLSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clsr_pkg.sv @@
// Constants and controller/datapath command types for the combined generator.
// No dependencies; used by every other file of the block but the macro header.
package clsr_pkg;

  localparam int WORD_W = 31;
  localparam int PROD_W = 47;
  localparam int WARMUP_EXTRA = 8;

  localparam logic [31:0] MOD_ONE      = 32'd2147483563;
  localparam logic [31:0] MOD_TWO      = 32'd2147483399;
  localparam logic [31:0] MOD_ONE_LESS = 32'd2147483562;
  localparam logic [15:0] MUL_ONE      = 16'd40014;
  localparam logic [15:0] MUL_TWO      = 16'd40692;
  // 2^31 mod each modulus, used to fold the high part of a product.
  localparam logic [7:0]  FOLD_ONE     = 8'd85;
  localparam logic [7:0]  FOLD_TWO     = 8'd249;
  localparam logic [WORD_W-1:0] SECOND_RESET = 31'd123456789;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic load_seed;
    logic mul_start;
    logic load_first;
    logic load_second;
    logic warm_write;
    logic word_from_gen;
    logic div_start;
    logic mem_read;
    logic finish;
  } clsr_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_busy;
  } clsr_stat_t;

endpackage

@@ sv/clsr_if.sv @@
// Handshake interfaces for the request and result channels.
// Depends on clsr_pkg for the payload type.
interface clsr_req_if;
  import clsr_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  word_t seed;
  modport source (output valid, output op, output seed, input ready);
  modport sink (input valid, input op, input seed, output ready);
endinterface

interface clsr_rsp_if;
  import clsr_pkg::*;
  logic  valid;
  logic  ready;
  word_t deviate;
  modport source (output valid, output deviate, input ready);
  modport sink (input valid, input deviate, output ready);
endinterface

@@ sv/clsr_mulmod.sv @@
// Two constant modular multipliers run in lockstep, three register stages.
// Depends on clsr_pkg for the multipliers, moduli and fold constants.
module clsr_mulmod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  clsr_pkg::word_t      x1,
  input  clsr_pkg::word_t      x2,
  output logic                 done,
  output clsr_pkg::word_t      r1,
  output clsr_pkg::word_t      r2
);
  import clsr_pkg::*;

  logic [PROD_W-1:0] p1;
  logic [PROD_W-1:0] p2;
  logic [31:0]       s1;
  logic [31:0]       s2;
  logic              v1;
  logic              v2;
  logic              v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Product = hi * 2^31 + lo, and 2^31 is congruent to the fold constant.
  // The folded sum stays below twice the modulus, so one subtraction ends it.
  always_ff @(posedge clk) begin
    p1 <= PROD_W'(x1) * PROD_W'(MUL_ONE);
    p2 <= PROD_W'(x2) * PROD_W'(MUL_TWO);
    s1 <= 32'(p1[WORD_W-1:0]) + 32'(p1[PROD_W-1:WORD_W]) * 32'(FOLD_ONE);
    s2 <= 32'(p2[WORD_W-1:0]) + 32'(p2[PROD_W-1:WORD_W]) * 32'(FOLD_TWO);
    r1 <= (s1 >= MOD_ONE) ? WORD_W'(s1 - MOD_ONE) : s1[WORD_W-1:0];
    r2 <= (s2 >= MOD_TWO) ? WORD_W'(s2 - MOD_TWO) : s2[WORD_W-1:0];
  end

  assign done = v3;

endmodule

@@ sv/clsr_datapath.sv @@
// Datapath: generator registers, shuffle table memory, slot divider, combiner.
// Depends on clsr_pkg, clsr_mulmod and the assertion macro header.
`include "combined_lcg_shuffle_rng_defines.svh"

module clsr_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  clsr_pkg::clsr_cmd_t              cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   warm_idx,
  input  clsr_pkg::word_t                  seed,
  output clsr_pkg::clsr_stat_t             stat,
  output clsr_pkg::word_t                  deviate
);
  import clsr_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int RW = IW + 1;
  localparam int PW = WORD_W + RW;
  localparam logic [31:0] SLOT_DIV   = 32'(MOD_ONE_LESS / 32'(TABLE_DEPTH)) + 32'd1;
  localparam logic [32:0] SPAN_FULL  = 33'h0_8000_0000;
  localparam logic [RW-1:0] RECIP    = RW'(SPAN_FULL / 33'(SLOT_DIV));

  word_t             first_gen;
  word_t             second_gen;
  word_t             shuffle_word;
  word_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  word_t             rd_data;
  logic              rd_valid;

  word_t             div_word;
  logic [RW-1:0]     q_est;
  logic [PW-1:0]     q_prod;
  logic [RW-1:0]     q_inc;
  logic [31:0]       q_thr;
  logic [RW-1:0]     q_fix;
  logic [IW-1:0]     slot;
  logic              div_busy;

  logic              mul_done;
  word_t             r1;
  word_t             r2;
  word_t             seed_fix;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  word_t             wr_data;
  word_t             entry;
  logic [31:0]       combo;

  clsr_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x1    (first_gen),
    .x2    (second_gen),
    .done  (mul_done),
    .r1    (r1),
    .r2    (r2)
  );

  assign seed_fix = (seed == '0) ? WORD_W'(1) : seed;

  // Entry minus second generator, wrapped into 1..2147483562.
  always_comb begin
    entry = rd_valid ? rd_data : '0;
    if (entry > second_gen) begin
      combo = 32'(entry) - 32'(second_gen);
    end else begin
      combo = 32'(entry) + MOD_ONE_LESS - 32'(second_gen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_gen    <= WORD_W'(1);
      second_gen   <= SECOND_RESET;
      shuffle_word <= '0;
    end else begin
      if (cmd.load_seed) begin
        first_gen  <= seed_fix;
        second_gen <= seed_fix;
      end
      if (cmd.load_first) begin
        first_gen <= r1;
      end
      if (cmd.load_second) begin
        second_gen <= r2;
      end
      if (cmd.word_from_gen) begin
        shuffle_word <= r1;
      end else if (cmd.finish) begin
        shuffle_word <= combo[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      deviate <= combo[WORD_W-1:0];
    end
  end

  // Shuffle table: one write port, one registered read port.
  assign wr_en   = cmd.warm_write || cmd.finish;
  assign wr_addr = cmd.finish ? slot : warm_idx;
  assign wr_data = cmd.finish ? first_gen : r1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_read) begin
      rd_data <= mem[slot];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.mem_read) begin
        rd_valid <= valid[slot];
      end
    end
  end

  // Slot divide. The reciprocal multiply, registered into q_est, gives the
  // quotient or one less; while div_busy the next multiple of the divisor is
  // checked and the result, clamped to the last table entry, goes into slot.
  assign q_prod = PW'(shuffle_word) * PW'(RECIP);
  assign q_inc  = q_est + RW'(1);
  assign q_thr  = 32'(q_inc) * SLOT_DIV;
  assign q_fix  = (32'(div_word) >= q_thr) ? q_inc : q_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      slot     <= '0;
      q_est    <= '0;
      div_word <= '0;
    end else if (cmd.div_start) begin
      div_word <= shuffle_word;
      q_est    <= q_prod[PW-1:WORD_W];
      div_busy <= 1'b1;
    end else if (div_busy) begin
      if (32'(q_fix) >= 32'(TABLE_DEPTH)) begin
        slot <= IW'(TABLE_DEPTH - 1);
      end else begin
        slot <= q_fix[IW-1:0];
      end
      div_busy <= 1'b0;
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.div_busy = div_busy;

  `CLSR_ASSERT_NEXT(a_deviate_range, cmd.finish, deviate != '0 && 32'(deviate) <= MOD_ONE_LESS, "deviate out of range")
  `CLSR_ASSERT_NOW(a_slot_range, !div_busy, 32'(slot) < 32'(TABLE_DEPTH), "slot beyond table")
  `CLSR_ASSERT_NOW(a_mulmod_reduced, mul_done, 32'(r1) < MOD_ONE && 32'(r2) < MOD_TWO, "mulmod not reduced")

endmodule

@@ sv/clsr_ctrl.sv @@
// Controller: sequences reseed warm-up and draws, owns both handshakes.
// Depends on clsr_pkg and the assertion macro header.
`include "combined_lcg_shuffle_rng_defines.svh"

module clsr_ctrl #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_op,
  output logic                             req_ready,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  input  clsr_pkg::clsr_stat_t             stat,
  output clsr_pkg::clsr_cmd_t              cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0]   warm_idx
);
  import clsr_pkg::*;

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int WCW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
  localparam logic [WCW-1:0] WARM_FIRST = WCW'(TABLE_DEPTH + WARMUP_EXTRA - 1);

  typedef enum logic [2:0] {
    IDLE,
    WARM_MUL,
    WARM_WAIT,
    DRAW_START,
    DRAW_WAIT,
    DIV_WAIT,
    READ,
    FINISH
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [WCW-1:0] warm_cnt;
  logic           accept;
  logic           warm_keep;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign warm_idx  = warm_cnt[IW-1:0];
  assign warm_keep = warm_cnt < WCW'(TABLE_DEPTH);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          if (req_op) begin
            cmd.load_seed = 1'b1;
            state_next    = WARM_MUL;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = DRAW_WAIT;
          end
        end
      end
      WARM_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = WARM_WAIT;
      end
      WARM_WAIT: begin
        if (stat.mul_done) begin
          cmd.load_first = 1'b1;
          cmd.warm_write = warm_keep;
          if (warm_cnt == '0) begin
            cmd.word_from_gen = 1'b1;
            state_next        = DRAW_START;
          end else begin
            state_next = WARM_MUL;
          end
        end
      end
      DRAW_START: begin
        cmd.mul_start = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = DRAW_WAIT;
      end
      DRAW_WAIT: begin
        if (stat.mul_done) begin
          cmd.load_first  = 1'b1;
          cmd.load_second = 1'b1;
          state_next      = DIV_WAIT;
        end
      end
      DIV_WAIT: begin
        if (!stat.div_busy) begin
          cmd.mem_read = 1'b1;
          state_next   = READ;
        end
      end
      READ: begin
        state_next = FINISH;
      end
      FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      warm_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_seed) begin
        warm_cnt <= WARM_FIRST;
      end else if (state == WARM_WAIT && stat.mul_done && warm_cnt != '0) begin
        warm_cnt <= warm_cnt - WCW'(1);
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `CLSR_ASSERT_NOW(a_mul_done_expected, stat.mul_done, state == WARM_WAIT || state == DRAW_WAIT, "multiplier result arrived unexpectedly")
  `CLSR_ASSERT_NOW(a_no_result_overwrite, cmd.finish, !rsp_valid || rsp_ready, "pending result overwritten")
  `CLSR_ASSERT_NEXT(a_one_at_a_time, accept, !req_ready, "second transaction taken while busy")

endmodule

@@ sv/combined_lcg_shuffle_rng.sv @@
// Top level of the combined congruential generator with shuffle table.
// Depends on clsr_pkg, clsr_if, clsr_ctrl and clsr_datapath.
//
//   channel | direction | payload
//   req     | in        | op (draw / reseed then draw), seed
//   rsp     | out       | deviate
//
// A draw starts the modular multipliers, three register stages, and the slot
// divide together; the divide runs under the multiply, then the table is read,
// the entry combined and rsp.valid raised; a draw ends before a new one is taken.
// A reseed first runs TABLE_DEPTH + 8 warm-up steps, one multiply each, then a draw.
// Synchronous reset restores the generators and marks every table entry zero.
// A new transaction is taken while a finished result still waits on rsp; its
// result then holds in the last step until the waiting one is accepted.
module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  clsr_req_if.sink   req,
  clsr_rsp_if.source rsp
);
  import clsr_pkg::*;

  clsr_cmd_t                      cmd;
  clsr_stat_t                     stat;
  logic [$clog2(TABLE_DEPTH)-1:0] warm_idx;

  clsr_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd),
    .warm_idx  (warm_idx)
  );

  clsr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .warm_idx (warm_idx),
    .seed     (req.seed),
    .stat     (stat),
    .deviate  (rsp.deviate)
  );

endmodule
